### hdl/cffs_pkg.sv
// Shared constants, types and arithmetic helpers for the cell fluid flow stencil.
// Stand-alone package; every other file of the block imports it.
package cffs_pkg;

    // Field and bus widths
    localparam int MASS_W = 16;             // Q4.12 mass / flow
    localparam int SUM_W  = MASS_W + 1;     // mass of two stacked cells
    localparam int FLOW_W = MASS_W + 2;     // signed raw flow before clamping
    localparam int DATA_W = 32;             // register bus
    localparam int ADDR_W = 3;              // two registers at 0x0 and 0x4

    // Register map, indexed by paddr[2]
    localparam logic REG_MIN_FLOW  = 1'b0;
    localparam logic REG_MAX_SPEED = 1'b1;

    localparam logic [MASS_W-1:0] MIN_FLOW_RST  = MASS_W'(41);
    localparam logic [MASS_W-1:0] MAX_SPEED_RST = MASS_W'(4096);

    // Fixed-point constants
    localparam int     FRAC_BITS = 12;
    localparam longint FIX_ONE   = longint'(1) << FRAC_BITS;
    localparam longint FIX_COMP  = (FIX_ONE + 10) / 20;      // 0.05 rounded
    localparam longint SM_DEN    = FIX_ONE + FIX_COMP;
    localparam longint HALF_DEN  = SM_DEN / 2;
    localparam longint MID_LIMIT = 2 * FIX_ONE + FIX_COMP;

    // Middle branch of the stable-mass split:
    //   ONE + ((m - ONE) * C + den/2) / den
    // The division is an exact reciprocal multiply; the two constant products
    // are folded so that a single multiplier serves the whole term.
    localparam int     OFF_W     = $clog2(SM_DEN);
    localparam longint X_MAX     = (SM_DEN - 1) * FIX_COMP + HALF_DEN;
    localparam int     X_W       = $clog2(X_MAX + 1);
    localparam int     RCP_SHIFT = X_W + $clog2(SM_DEN);
    localparam longint RECIP     = ((longint'(1) << RCP_SHIFT) + SM_DEN - 1) / SM_DEN;
    localparam longint MUL_K     = FIX_COMP * RECIP;
    localparam longint MUL_BIAS  = HALF_DEN * RECIP;
    localparam int     COMP_W    = $clog2(FIX_COMP + 2);
    localparam int     PROD_W    = RCP_SHIFT + COMP_W;

    // Stable-mass branch codes
    localparam logic [1:0] SM_UNIT = 2'd0;  // m <= ONE
    localparam logic [1:0] SM_MID  = 2'd1;  // ONE < m < 2*ONE + C
    localparam logic [1:0] SM_HALF = 2'd2;  // otherwise

    // Which of the four flows may be non-zero for this cell
    typedef struct packed {
        logic down;
        logic left;
        logic right;
        logic up;
    } t_flow_en;

    function automatic logic [1:0] sm_class(input logic [SUM_W-1:0] m);
        logic [1:0] cls;
        if (m <= SUM_W'(FIX_ONE)) begin
            cls = SM_UNIT;
        end else if (m < SUM_W'(MID_LIMIT)) begin
            cls = SM_MID;
        end else begin
            cls = SM_HALF;
        end
        return cls;
    endfunction

    function automatic logic [PROD_W-1:0] sm_product(input logic [SUM_W-1:0] m);
        logic [OFF_W-1:0] off;
        off = OFF_W'(m - SUM_W'(FIX_ONE));
        return PROD_W'(off) * PROD_W'(MUL_K);
    endfunction

    function automatic logic [SUM_W-1:0] sm_finish(
        input logic [1:0]        cls,
        input logic [SUM_W-1:0]  m,
        input logic [PROD_W-1:0] prod
    );
        logic [PROD_W-1:0] biased;
        logic [SUM_W:0]    half_sum;
        logic [SUM_W-1:0]  res;
        biased   = prod + PROD_W'(MUL_BIAS);
        half_sum = {1'b0, m} + (SUM_W + 1)'(FIX_COMP);
        case (cls)
            SM_UNIT: res = SUM_W'(FIX_ONE);
            SM_MID:  res = SUM_W'(FIX_ONE) + SUM_W'(biased >> RCP_SHIFT);
            SM_HALF: res = half_sum[SUM_W:1];
            default: res = SUM_W'(FIX_ONE);
        endcase
        return res;
    endfunction

    // Halve above min_flow, then clamp into [0, hi]
    function automatic logic [MASS_W-1:0] shape_flow(
        input logic signed [FLOW_W-1:0] f,
        input logic [MASS_W-1:0]        min_flow,
        input logic [MASS_W-1:0]        hi
    );
        logic signed [FLOW_W-1:0] g;
        logic [MASS_W-1:0]        res;
        g = f;
        if (f > $signed({2'b00, min_flow})) begin
            g = f >>> 1;
        end
        if (g > $signed({2'b00, hi})) begin
            res = hi;
        end else if (g < $signed(FLOW_W'(0))) begin
            res = '0;
        end else begin
            res = g[MASS_W-1:0];
        end
        return res;
    endfunction

    // Quarter of a positive difference, halved above min_flow (unclamped)
    function automatic logic [MASS_W-1:0] horiz_flow(
        input logic [MASS_W-1:0] c,
        input logic [MASS_W-1:0] n,
        input logic [MASS_W-1:0] min_flow
    );
        logic [MASS_W-1:0] d;
        logic [MASS_W-1:0] q;
        d = (c > n) ? (c - n) : '0;
        q = d >> 2;
        return (q > min_flow) ? (q >> 1) : q;
    endfunction

    function automatic logic [MASS_W-1:0] min_mass(
        input logic [MASS_W-1:0] a,
        input logic [MASS_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

### hdl/cell_fluid_flow_stencil.sv
// Cell fluid flow stencil: per-cell push flows (down, left, right, up) of a grid water rule.
// Depends on cffs_pkg for widths, fixed-point constants and the flow arithmetic.
// Each accepted input transaction passes registers A, B, C, D, E and the output register.
// Throughput: one transaction per cycle while the result is not held by i_stall, with the six-register
// pipeline; a full pipeline held by i_stall stops taking input only once every stage is occupied.
// Reset (i_rst_n low, synchronous): pipeline emptied, min_flow = 41, max_speed = 4096.
module cell_fluid_flow_stencil
    import cffs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MASS_W-1:0] i_center_mass,
    input  logic [MASS_W-1:0] i_up_mass,
    input  logic [MASS_W-1:0] i_left_mass,
    input  logic [MASS_W-1:0] i_right_mass,
    input  logic [MASS_W-1:0] i_down_mass,
    input  logic              i_center_solid,
    input  logic              i_up_solid,
    input  logic              i_left_solid,
    input  logic              i_right_solid,
    input  logic              i_down_solid,

    // Result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [MASS_W-1:0] o_flow_down,
    output logic [MASS_W-1:0] o_flow_left,
    output logic [MASS_W-1:0] o_flow_right,
    output logic [MASS_W-1:0] o_flow_up,

    // Register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the pipe is
    // empty (the block does not enforce it), so the stages read them directly.
    // ------------------------------------------------------------------
    logic [MASS_W-1:0] r_min_flow;
    logic [MASS_W-1:0] r_max_speed;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_flow  <= MIN_FLOW_RST;
            r_max_speed <= MAX_SPEED_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MIN_FLOW:  r_min_flow  <= pwdata[MASS_W-1:0];
                REG_MAX_SPEED: r_max_speed <= pwdata[MASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MIN_FLOW:  prdata = {{(DATA_W-MASS_W){1'b0}}, r_min_flow};
            REG_MAX_SPEED: prdata = {{(DATA_W-MASS_W){1'b0}}, r_max_speed};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage takes new data when it is empty or
    // when the stage after it moves, so bubbles collapse and a held result
    // does not block the stages behind it until they fill.
    // ------------------------------------------------------------------
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_o_vld;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_o;

    assign rdy_o   = !r_o_vld || !i_stall;
    assign rdy_e   = !r_e_vld || rdy_o;
    assign rdy_d   = !r_d_vld || rdy_e;
    assign rdy_c   = !r_c_vld || rdy_d;
    assign rdy_b   = !r_b_vld || rdy_c;
    assign rdy_a   = !r_a_vld || rdy_b;
    assign o_stall = !rdy_a;
    assign o_valid = r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (rdy_a) r_a_vld <= i_valid;
            if (rdy_b) r_b_vld <= r_a_vld;
            if (rdy_c) r_c_vld <= r_b_vld;
            if (rdy_d) r_d_vld <= r_c_vld;
            if (rdy_e) r_e_vld <= r_d_vld;
            if (rdy_o) r_o_vld <= r_e_vld;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register.
    // ------------------------------------------------------------------
    logic [MASS_W-1:0] r_a_center, r_a_up, r_a_left, r_a_right, r_a_down;
    logic              r_a_cs;
    t_flow_en          r_a_ns;      // neighbour solid flags

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_center <= i_center_mass;
            r_a_up     <= i_up_mass;
            r_a_left   <= i_left_mass;
            r_a_right  <= i_right_mass;
            r_a_down   <= i_down_mass;
            r_a_cs     <= i_center_solid;
            r_a_ns     <= '{down: i_down_solid, left: i_left_solid,
                            right: i_right_solid, up: i_up_solid};
        end
    end

    // ------------------------------------------------------------------
    // Stage B: downward stable-mass product, branch select, flow enables
    // and the unclamped sideways flows (these need no running mass yet).
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  n_b_sum;
    t_flow_en          n_b_en;
    logic [MASS_W-1:0] r_b_center, r_b_up, r_b_down, r_b_hl, r_b_hr;
    logic [SUM_W-1:0]  r_b_sum;
    logic [1:0]        r_b_cls;
    logic [PROD_W-1:0] r_b_prod;
    t_flow_en          r_b_en;

    assign n_b_sum = {1'b0, r_a_center} + {1'b0, r_a_down};

    // A solid centre moves nothing; a solid neighbour takes nothing.
    assign n_b_en = '{down:  !r_a_cs && !r_a_ns.down,
                      left:  !r_a_cs && !r_a_ns.left,
                      right: !r_a_cs && !r_a_ns.right,
                      up:    !r_a_cs && !r_a_ns.up};

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_center <= r_a_center;
            r_b_up     <= r_a_up;
            r_b_down   <= r_a_down;
            r_b_sum    <= n_b_sum;
            r_b_cls    <= sm_class(n_b_sum);
            r_b_prod   <= sm_product(n_b_sum);
            r_b_en     <= n_b_en;
            r_b_hl     <= horiz_flow(r_a_center, r_a_left, r_min_flow);
            r_b_hr     <= horiz_flow(r_a_center, r_a_right, r_min_flow);
        end
    end

    // ------------------------------------------------------------------
    // Stage C: down flow, clamped to max_speed and to the cell's mass.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]         c_stable;
    logic signed [FLOW_W-1:0] c_raw;
    logic [MASS_W-1:0]        n_c_fd;
    logic [MASS_W-1:0]        r_c_fd, r_c_rem1, r_c_up, r_c_hl, r_c_hr;
    t_flow_en                 r_c_en;

    assign c_stable = sm_finish(r_b_cls, r_b_sum, r_b_prod);
    assign c_raw    = $signed({1'b0, c_stable}) - $signed({2'b00, r_b_down});
    assign n_c_fd   = r_b_en.down
                    ? shape_flow(c_raw, r_min_flow, min_mass(r_max_speed, r_b_center))
                    : '0;

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_fd   <= n_c_fd;
            r_c_rem1 <= r_b_center - n_c_fd;
            r_c_up   <= r_b_up;
            r_c_hl   <= r_b_hl;
            r_c_hr   <= r_b_hr;
            r_c_en   <= r_b_en;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: left then right flow against the running remainder.
    // ------------------------------------------------------------------
    logic [MASS_W-1:0] d_fl, d_rem2, d_fr;
    logic [MASS_W-1:0] r_d_fd, r_d_fl, r_d_fr, r_d_rem3, r_d_up;
    logic              r_d_en_up;

    assign d_fl   = r_c_en.left ? min_mass(r_c_hl, r_c_rem1) : '0;
    assign d_rem2 = r_c_rem1 - d_fl;
    assign d_fr   = r_c_en.right ? min_mass(r_c_hr, d_rem2) : '0;

    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_d_fd    <= r_c_fd;
            r_d_fl    <= d_fl;
            r_d_fr    <= d_fr;
            r_d_rem3  <= d_rem2 - d_fr;
            r_d_up    <= r_c_up;
            r_d_en_up <= r_c_en.up;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: upward stable-mass product on remainder plus cell above.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  n_e_sum;
    logic [MASS_W-1:0] r_e_fd, r_e_fl, r_e_fr, r_e_rem3;
    logic [SUM_W-1:0]  r_e_sum;
    logic [1:0]        r_e_cls;
    logic [PROD_W-1:0] r_e_prod;
    logic              r_e_en_up;

    assign n_e_sum = {1'b0, r_d_rem3} + {1'b0, r_d_up};

    always_ff @(posedge i_clk) begin
        if (rdy_e) begin
            r_e_fd    <= r_d_fd;
            r_e_fl    <= r_d_fl;
            r_e_fr    <= r_d_fr;
            r_e_rem3  <= r_d_rem3;
            r_e_sum   <= n_e_sum;
            r_e_cls   <= sm_class(n_e_sum);
            r_e_prod  <= sm_product(n_e_sum);
            r_e_en_up <= r_d_en_up;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: up flow, then the result register.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]         f_stable;
    logic signed [FLOW_W-1:0] f_raw;
    logic [MASS_W-1:0]        r_o_fd, r_o_fl, r_o_fr, r_o_fu;

    assign f_stable = sm_finish(r_e_cls, r_e_sum, r_e_prod);
    assign f_raw    = $signed({2'b00, r_e_rem3}) - $signed({1'b0, f_stable});

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_o_fd <= r_e_fd;
            r_o_fl <= r_e_fl;
            r_o_fr <= r_e_fr;
            r_o_fu <= r_e_en_up
                    ? shape_flow(f_raw, r_min_flow, min_mass(r_max_speed, r_e_rem3))
                    : '0;
        end
    end

    assign o_flow_down  = r_o_fd;
    assign o_flow_left  = r_o_fl;
    assign o_flow_right = r_o_fr;
    assign o_flow_up    = r_o_fu;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_vld && r_b_vld && r_c_vld && r_d_vld && r_e_vld && r_o_vld))
        else $error("input stalled with a free pipeline stage");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_a_vld)
        else $error("accepted transaction not captured");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && rdy_o) |=> o_valid)
        else $error("transaction lost entering the result register");

    a_vert_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_flow_down <= r_max_speed && o_flow_up <= r_max_speed))
        else $error("vertical flow above max_speed");

endmodule
